### hdl/mar_pkg.sv
package mar_pkg;

  // field widths
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 4;
  localparam int ANG_W   = 16;
  localparam int OP_W    = 3;
  localparam int ELEMS   = 16;

  // stream packing
  localparam int IN_TDATA_W  = 152;
  localparam int OUT_TDATA_W = 40;

  // internal widths
  localparam int TRIG_W  = 18;   // sine and cosine, Q2.16
  localparam int UNIT_W  = 18;   // unit axis components, Q2.16
  localparam int RM_W    = 20;   // rotation matrix entries
  localparam int ACC_W   = 56;   // dot product accumulator, Q32
  localparam int MUL_W   = 33;   // shared multiplier operand
  localparam int PROD_W  = 2 * MUL_W;
  localparam int LSQ_W   = 64;   // squared axis length
  localparam int CZ_W    = 33;   // cordic x, y, z registers
  localparam int RED_W   = 13;   // reduced angle, up to 90 degrees in Q10.6
  localparam int QUO_W   = 18;   // quotient bits of the axis divide

  localparam int CORDIC_ITER_DEF = 16;

  // angle constants in Q10.6 degrees
  localparam int DEG360      = 23040;
  localparam int DEG180      = 11520;
  localparam int DEG90       = 5760;
  localparam int RAD_PER_DEG = 292818;     // Q2.30 radians per Q10.6 degree
  localparam int CORDIC_X0   = 652032874;  // inverse gain, Q30

  localparam logic signed [DATA_W-1:0] ONE_Q16 = 32'sd65536;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 3'd0,
    OP_AXIS  = 3'd1,
    OP_ROT_X = 3'd2,
    OP_ROT_Y = 3'd3,
    OP_ROT_Z = 3'd4,
    OP_READ  = 3'd5
  } op_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } trig_t;

  typedef struct packed {
    logic signed [UNIT_W-1:0] x;
    logic signed [UNIT_W-1:0] y;
    logic signed [UNIT_W-1:0] z;
  } unit_vec_t;

  // arctangent of 2^-i in Q30 radians
  function automatic logic signed [CZ_W-1:0] atan_q30(input logic [4:0] i);
    logic signed [CZ_W-1:0] v;
    begin
      case (i)
        5'd0:  v = 33'sd843314856;
        5'd1:  v = 33'sd497837829;
        5'd2:  v = 33'sd263043836;
        5'd3:  v = 33'sd133525158;
        5'd4:  v = 33'sd67021686;
        5'd5:  v = 33'sd33543515;
        5'd6:  v = 33'sd16775850;
        5'd7:  v = 33'sd8388437;
        5'd8:  v = 33'sd4194282;
        5'd9:  v = 33'sd2097149;
        5'd10: v = 33'sd1048575;
        5'd11: v = 33'sd524287;
        5'd12: v = 33'sd262143;
        5'd13: v = 33'sd131071;
        5'd14: v = 33'sd65535;
        5'd15: v = 33'sd32767;
        5'd16: v = 33'sd16383;
        5'd17: v = 33'sd8191;
        5'd18: v = 33'sd4095;
        5'd19: v = 33'sd2047;
        5'd20: v = 33'sd1023;
        5'd21: v = 33'sd511;
        5'd22: v = 33'sd255;
        5'd23: v = 33'sd127;
        5'd24: v = 33'sd63;
        5'd25: v = 33'sd31;
        5'd26: v = 33'sd15;
        5'd27: v = 33'sd7;
        5'd28: v = 33'sd3;
        5'd29: v = 33'sd1;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

### hdl/mar_cordic.sv
module mar_cordic #(
  parameter int ITERATIONS = mar_pkg::CORDIC_ITER_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [mar_pkg::ANG_W-1:0] angle,
  output logic                             trig_valid,
  output mar_pkg::trig_t                   trig
);
  import mar_pkg::*;

  localparam int IW = $clog2(ITERATIONS);

  typedef enum logic [1:0] {C_IDLE, C_LOAD, C_ITER, C_FIN} cstate_t;

  cstate_t                  state_r;
  logic [IW-1:0]            i_r;
  logic [RED_W-1:0]         red_r;
  logic                     neg_both_r;
  logic                     neg_cos_r;
  logic signed [CZ_W-1:0]   x_r, y_r, z_r;
  logic                     valid_r;
  trig_t                    trig_r;

  // angle reduction into the first quadrant
  logic signed [ANG_W+1:0]  a_ext, a_p1, a_p2, a_m1, r0, r1;
  logic                     nb, ncs;
  logic [RED_W-1:0]         r2;

  always_comb begin
    a_ext = (ANG_W+2)'(angle);
    a_p1  = a_ext + (ANG_W+2)'(DEG360);
    a_p2  = a_ext + (ANG_W+2)'(2 * DEG360);
    a_m1  = a_ext - (ANG_W+2)'(DEG360);
    if (a_ext < 0) begin
      r0 = (a_p1 < 0) ? a_p2 : a_p1;
    end else begin
      r0 = (a_ext >= (ANG_W+2)'(DEG360)) ? a_m1 : a_ext;
    end
    nb = (r0 >= (ANG_W+2)'(DEG180));
    r1 = nb ? (r0 - (ANG_W+2)'(DEG180)) : r0;
    ncs = (r1 > (ANG_W+2)'(DEG90));
    r2 = ncs ? RED_W'((ANG_W+2)'(DEG180) - r1) : RED_W'(r1);
  end

  // one rotation step
  logic signed [CZ_W-1:0] xs, ys, at;
  logic signed [CZ_W-1:0] xr, yr;

  always_comb begin
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    at = atan_q30(5'(i_r));
    xr = (x_r + CZ_W'(8192)) >>> 14;
    yr = (y_r + CZ_W'(8192)) >>> 14;
  end

  // sequencer and rotation registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      valid_r <= 1'b0;
      i_r     <= '0;
    end else if (start) begin
      red_r      <= r2;
      neg_both_r <= nb;
      neg_cos_r  <= ncs;
      valid_r    <= 1'b0;
      state_r    <= C_LOAD;
    end else begin
      case (state_r)
        C_LOAD: begin
          x_r     <= CZ_W'(CORDIC_X0);
          y_r     <= '0;
          z_r     <= $signed({{(CZ_W-RED_W){1'b0}}, red_r}) * CZ_W'(RAD_PER_DEG);
          i_r     <= '0;
          state_r <= C_ITER;
        end
        C_ITER: begin
          if (z_r >= 0) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - at;
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + at;
          end
          i_r <= i_r + 1'b1;
          if (i_r == IW'(ITERATIONS - 1)) begin
            state_r <= C_FIN;
          end
        end
        C_FIN: begin
          trig_r.cos_v <= (neg_cos_r ^ neg_both_r) ? -TRIG_W'(xr) : TRIG_W'(xr);
          trig_r.sin_v <= neg_both_r ? -TRIG_W'(yr) : TRIG_W'(yr);
          valid_r      <= 1'b1;
          state_r      <= C_IDLE;
        end
        default: begin
          state_r <= C_IDLE;
        end
      endcase
    end
  end

  assign trig_valid = valid_r;
  assign trig       = trig_r;

endmodule

### hdl/mar_norm.sv
module mar_norm (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [mar_pkg::LSQ_W-1:0]         lsq,
  input  logic signed [mar_pkg::DATA_W-1:0] axis_x,
  input  logic signed [mar_pkg::DATA_W-1:0] axis_y,
  input  logic signed [mar_pkg::DATA_W-1:0] axis_z,
  output logic                              done,
  output mar_pkg::unit_vec_t                unit
);
  import mar_pkg::*;

  localparam int LEN_W = LSQ_W / 2;

  typedef enum logic [1:0] {N_IDLE, N_SQRT, N_DINIT, N_DIV} nstate_t;

  nstate_t              state_r;
  logic [4:0]           cnt_r;
  logic [1:0]           comp_r;
  logic [LSQ_W-1:0]     src_r;
  logic [LEN_W:0]       rem_r;
  logic [LEN_W-1:0]     res_r;
  logic [DATA_W-1:0]    mag_r [3];
  logic [2:0]           neg_r;
  logic [LEN_W:0]       drem_r;
  logic [QUO_W-1:0]     dsh_r;
  logic [QUO_W-1:0]     q_r;
  logic                 done_r;
  unit_vec_t            unit_r;

  // magnitudes of the axis components
  function automatic logic [DATA_W-1:0] mag_of(input logic signed [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

  // square root digit step
  logic [LEN_W+1:0] sq_sh, sq_trial;
  always_comb begin
    sq_sh    = {rem_r[LEN_W-1:0], src_r[LSQ_W-1:LSQ_W-2]};
    sq_trial = {res_r, 2'b01};
  end

  // divide setup and step
  logic [DATA_W+15:0] num;
  logic [LEN_W:0]     dv_sh;
  logic [QUO_W-1:0]   q_fin;
  logic signed [UNIT_W-1:0] u_fin;
  always_comb begin
    num   = {mag_r[comp_r], 16'b0} + {17'b0, res_r[LEN_W-1:1]};
    dv_sh = {drem_r[LEN_W-1:0], dsh_r[QUO_W-1]};
    q_fin = {q_r[QUO_W-2:0], (dv_sh >= {1'b0, res_r})};
    u_fin = neg_r[comp_r] ? -$signed(UNIT_W'(q_fin)) : $signed(UNIT_W'(q_fin));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
      comp_r  <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        N_IDLE: begin
          if (start) begin
            src_r    <= lsq;
            rem_r    <= '0;
            res_r    <= '0;
            cnt_r    <= '0;
            mag_r[0] <= mag_of(axis_x);
            mag_r[1] <= mag_of(axis_y);
            mag_r[2] <= mag_of(axis_z);
            neg_r    <= {axis_z[DATA_W-1], axis_y[DATA_W-1], axis_x[DATA_W-1]};
            state_r  <= N_SQRT;
          end
        end
        N_SQRT: begin
          if (sq_sh >= sq_trial) begin
            rem_r <= (LEN_W+1)'(sq_sh - sq_trial);
            res_r <= {res_r[LEN_W-2:0], 1'b1};
          end else begin
            rem_r <= (LEN_W+1)'(sq_sh);
            res_r <= {res_r[LEN_W-2:0], 1'b0};
          end
          src_r <= {src_r[LSQ_W-3:0], 2'b00};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'(LEN_W - 1)) begin
            comp_r  <= '0;
            state_r <= N_DINIT;
          end
        end
        N_DINIT: begin
          drem_r  <= {{(LEN_W+1-(DATA_W+16-QUO_W)){1'b0}}, num[DATA_W+15:QUO_W]};
          dsh_r   <= num[QUO_W-1:0];
          q_r     <= '0;
          cnt_r   <= '0;
          state_r <= N_DIV;
        end
        N_DIV: begin
          if (dv_sh >= {1'b0, res_r}) begin
            drem_r <= dv_sh - {1'b0, res_r};
          end else begin
            drem_r <= dv_sh;
          end
          q_r   <= q_fin;
          dsh_r <= {dsh_r[QUO_W-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'(QUO_W - 1)) begin
            case (comp_r)
              2'd0:    unit_r.x <= u_fin;
              2'd1:    unit_r.y <= u_fin;
              default: unit_r.z <= u_fin;
            endcase
            if (comp_r == 2'd2) begin
              done_r  <= 1'b1;
              state_r <= N_IDLE;
            end else begin
              comp_r  <= comp_r + 1'b1;
              state_r <= N_DINIT;
            end
          end
        end
        default: begin
          state_r <= N_IDLE;
        end
      endcase
    end
  end

  assign done = done_r;
  assign unit = unit_r;

endmodule

### hdl/matrix_axis_angle_rotate_core.sv
// channel | ports                       | payload
// in      | in_tvalid in_tready         | tuser: operation; tdata: index, value, angle, x, y, z
// out     | out_tvalid out_tready       | tdata: index, value; tlast; tuser: axis_error
//
// a load is written as it is accepted; read out streams 16 items from the matrix memory read port
// rotate about X, Y or Z: cordic, then multiply-accumulate over the shared 33x33 multiplier, then read out
// axis rotate adds squares, square root, divides and matrix build ahead of the multiply-accumulate
// reset restores the identity matrix at once through per-element valid bits; no clearing pass
// a stalled output holds its item; a new item is taken while the last result still waits
module matrix_axis_angle_rotate_core #(
  parameter int CORDIC_ITERATIONS = mar_pkg::CORDIC_ITER_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // element_index, element_value, angle_deg, axis_x, axis_y, axis_z
  input  logic [mar_pkg::IN_TDATA_W-1:0]        in_tdata,
  // operation
  input  logic [mar_pkg::OP_W-1:0]              in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // out_index, out_value
  output logic [mar_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                  out_tlast,
  // axis_error
  output logic [0:0]                            out_tuser
);
  import mar_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SQUARE, S_NORM, S_TRIG, S_BUILD, S_MAC, S_STREAM
  } state_t;

  // input fields
  logic [IDX_W-1:0]         f_idx;
  logic signed [DATA_W-1:0] f_val;
  logic signed [ANG_W-1:0]  f_ang;
  logic signed [DATA_W-1:0] f_x, f_y, f_z;
  op_t                      f_op;

  assign f_idx = in_tdata[3:0];
  assign f_val = in_tdata[35:4];
  assign f_ang = in_tdata[51:36];
  assign f_x   = in_tdata[83:52];
  assign f_y   = in_tdata[115:84];
  assign f_z   = in_tdata[147:116];
  assign f_op  = op_t'(in_tuser);

  // control and datapath registers
  state_t                   state_r;
  logic [6:0]               step_r;
  op_t                      op_r;
  logic                     err_r;
  logic                     bank_r;
  logic [ELEMS-1:0]         vld_r;
  logic signed [DATA_W-1:0] ax_r, ay_r, az_r;
  logic [LSQ_W-1:0]         lsq_r;
  logic signed [UNIT_W-1:0] ux_r, uy_r, uz_r;
  logic signed [RM_W-1:0]   t_r [9];
  logic signed [RM_W-1:0]   rm_r [ELEMS];
  logic signed [ACC_W-1:0]  acc_r;
  logic                     p_v_r;
  logic [6:0]               p_tag_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     s1_v_r;
  logic [5:0]               s1_step_r;
  logic [IDX_W-1:0]         rd_idx_r;
  logic                     pend_r;
  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_index_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_last_r;
  logic                     out_err_r;

  // matrix memory, two banks of 16
  logic signed [DATA_W-1:0] mem [2*ELEMS];
  logic signed [DATA_W-1:0] mem_q;
  logic                     rd_en, we;
  logic [IDX_W:0]           rd_addr, wa;
  logic signed [DATA_W-1:0] wd;

  // trig and normalize units
  logic      trig_valid;
  trig_t     trig;
  logic      cordic_start;
  logic      norm_start, norm_done;
  unit_vec_t unit;

  mar_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (cordic_start),
    .angle      (f_ang),
    .trig_valid (trig_valid),
    .trig       (trig)
  );

  mar_norm u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (norm_start),
    .lsq    (lsq_r),
    .axis_x (ax_r),
    .axis_y (ay_r),
    .axis_z (az_r),
    .done   (norm_done),
    .unit   (unit)
  );

  function automatic logic signed [MUL_W-1:0] abs33(input logic signed [DATA_W-1:0] v);
    logic signed [MUL_W-1:0] e;
    begin
      e = MUL_W'(v);
      return v[DATA_W-1] ? -e : e;
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] ident_val(input logic [IDX_W-1:0] i);
    return (i[1:0] == i[3:2]) ? ONE_Q16 : '0;
  endfunction

  function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] s);
    logic signed [ACC_W-1:0] v;
    begin
      v = (s + ACC_W'(32768)) >>> 16;
      if (v > ACC_W'(32'sh7fffffff)) begin
        return 32'sh7fffffff;
      end else if (v < -ACC_W'(33'sh080000000)) begin
        return 32'sh80000000;
      end
      return DATA_W'(v);
    end
  endfunction

  // accepted item and handshakes
  logic accept;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cordic_start = accept && (f_op == OP_AXIS || f_op == OP_ROT_X ||
                                   f_op == OP_ROT_Y || f_op == OP_ROT_Z);

  logic lsq_zero, lsq_unit;
  assign lsq_zero   = (lsq_r == '0);
  assign lsq_unit   = (lsq_r == (LSQ_W'(1) << 32));
  assign norm_start = (state_r == S_SQUARE) && (step_r == 7'd4) && !lsq_zero && !lsq_unit;

  // memory read data, unwritten elements read as identity
  logic signed [DATA_W-1:0] rdata_eff;
  assign rdata_eff = vld_r[rd_idx_r] ? mem_q : ident_val(rd_idx_r);

  logic stream_issue;
  assign stream_issue = (state_r == S_STREAM) && !pend_r && (step_r < 7'd16) &&
                        (!out_valid_r || out_tready);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {bank_r, step_r[3:0]};
    if (state_r == S_MAC) begin
      rd_en   = (step_r < 7'd64);
      rd_addr = {bank_r, step_r[1:0], step_r[3:2]};
    end else if (stream_issue) begin
      rd_en = 1'b1;
    end
  end

  // shared multiplier operand select
  logic signed [TRIG_W:0]    nc;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic                      mul_v;
  logic [6:0]                mul_tag;

  assign nc = (TRIG_W+1)'(ONE_Q16) - (TRIG_W+1)'(trig.cos_v);

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_v   = 1'b0;
    mul_tag = step_r;
    case (state_r)
      S_SQUARE: begin
        mul_v = (step_r < 7'd3);
        case (step_r[1:0])
          2'd0:    begin mul_a = abs33(ax_r); mul_b = abs33(ax_r); end
          2'd1:    begin mul_a = abs33(ay_r); mul_b = abs33(ay_r); end
          default: begin mul_a = abs33(az_r); mul_b = abs33(az_r); end
        endcase
      end
      S_BUILD: begin
        mul_v = (step_r < 7'd15);
        case (step_r[3:0])
          4'd0:    begin mul_a = MUL_W'(ux_r);   mul_b = MUL_W'(ux_r); end
          4'd1:    begin mul_a = MUL_W'(uy_r);   mul_b = MUL_W'(uy_r); end
          4'd2:    begin mul_a = MUL_W'(uz_r);   mul_b = MUL_W'(uz_r); end
          4'd3:    begin mul_a = MUL_W'(ux_r);   mul_b = MUL_W'(uy_r); end
          4'd4:    begin mul_a = MUL_W'(uy_r);   mul_b = MUL_W'(uz_r); end
          4'd5:    begin mul_a = MUL_W'(uz_r);   mul_b = MUL_W'(ux_r); end
          4'd6:    begin mul_a = MUL_W'(ux_r);   mul_b = MUL_W'(trig.sin_v); end
          4'd7:    begin mul_a = MUL_W'(uy_r);   mul_b = MUL_W'(trig.sin_v); end
          4'd8:    begin mul_a = MUL_W'(uz_r);   mul_b = MUL_W'(trig.sin_v); end
          4'd9:    begin mul_a = MUL_W'(t_r[0]); mul_b = MUL_W'(nc); end
          4'd10:   begin mul_a = MUL_W'(t_r[1]); mul_b = MUL_W'(nc); end
          4'd11:   begin mul_a = MUL_W'(t_r[2]); mul_b = MUL_W'(nc); end
          4'd12:   begin mul_a = MUL_W'(t_r[3]); mul_b = MUL_W'(nc); end
          4'd13:   begin mul_a = MUL_W'(t_r[4]); mul_b = MUL_W'(nc); end
          default: begin mul_a = MUL_W'(t_r[5]); mul_b = MUL_W'(nc); end
        endcase
      end
      S_MAC: begin
        mul_v   = s1_v_r;
        mul_tag = {1'b0, s1_step_r};
        mul_a   = MUL_W'(rdata_eff);
        mul_b   = MUL_W'(rm_r[{s1_step_r[5:4], s1_step_r[1:0]}]);
      end
      default: begin
        mul_v = 1'b0;
      end
    endcase
  end

  // product register
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // product writeback values
  logic signed [RM_W-1:0]  q_b;
  logic signed [PROD_W-1:0] q_sh;
  logic signed [ACC_W-1:0] acc_sum;
  logic                    we_mac;

  always_comb begin
    q_sh    = (prod_r + PROD_W'(32768)) >>> 16;
    q_b     = RM_W'(q_sh);
    acc_sum = ((p_tag_r[1:0] == 2'd0) ? '0 : acc_r) + prod_r[ACC_W-1:0];
    we_mac  = (state_r == S_MAC) && p_v_r && (p_tag_r[1:0] == 2'd3);
  end

  // memory write select
  always_comb begin
    we = 1'b0;
    wa = {bank_r, f_idx};
    wd = f_val;
    if (accept && f_op == OP_LOAD) begin
      we = 1'b1;
    end else if (we_mac) begin
      we = 1'b1;
      wa = {~bank_r, p_tag_r[5:2]};
      wd = round_sat(acc_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      op_r        <= OP_READ;
      err_r       <= 1'b0;
      bank_r      <= 1'b0;
      vld_r       <= '0;
      p_v_r       <= 1'b0;
      s1_v_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p_v_r     <= mul_v;
      p_tag_r   <= mul_tag;
      s1_v_r    <= (state_r == S_MAC) && rd_en;
      s1_step_r <= step_r[5:0];
      pend_r    <= stream_issue;
      if (rd_en) begin
        rd_idx_r <= rd_addr[IDX_W-1:0];
      end
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            err_r  <= 1'b0;
            op_r   <= f_op;
            step_r <= '0;
            case (f_op)
              OP_LOAD: begin
                vld_r[f_idx] <= 1'b1;
              end
              OP_AXIS: begin
                ax_r    <= f_x;
                ay_r    <= f_y;
                az_r    <= f_z;
                lsq_r   <= '0;
                state_r <= S_SQUARE;
              end
              OP_ROT_X, OP_ROT_Y, OP_ROT_Z: begin
                state_r <= S_TRIG;
              end
              OP_READ: begin
                state_r <= S_STREAM;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end

        // squared axis length
        S_SQUARE: begin
          step_r <= step_r + 1'b1;
          if (p_v_r) begin
            lsq_r <= lsq_r + prod_r[LSQ_W-1:0];
          end
          if (step_r == 7'd4) begin
            step_r <= '0;
            if (lsq_zero) begin
              err_r   <= 1'b1;
              state_r <= S_STREAM;
            end else if (lsq_unit) begin
              ux_r    <= UNIT_W'(ax_r);
              uy_r    <= UNIT_W'(ay_r);
              uz_r    <= UNIT_W'(az_r);
              state_r <= S_TRIG;
            end else begin
              state_r <= S_NORM;
            end
          end
        end

        S_NORM: begin
          if (norm_done) begin
            ux_r    <= unit.x;
            uy_r    <= unit.y;
            uz_r    <= unit.z;
            state_r <= S_TRIG;
          end
        end

        // rotation matrix defaults, column rotates filled directly
        S_TRIG: begin
          if (trig_valid) begin
            for (int k = 0; k < ELEMS; k++) begin
              rm_r[k] <= '0;
            end
            rm_r[15] <= RM_W'(ONE_Q16);
            step_r   <= '0;
            case (op_r)
              OP_ROT_X: begin
                rm_r[0]  <= RM_W'(ONE_Q16);
                rm_r[5]  <= RM_W'(trig.cos_v);
                rm_r[6]  <= RM_W'(trig.sin_v);
                rm_r[9]  <= -RM_W'(trig.sin_v);
                rm_r[10] <= RM_W'(trig.cos_v);
                state_r  <= S_MAC;
              end
              OP_ROT_Y: begin
                rm_r[0]  <= RM_W'(trig.cos_v);
                rm_r[2]  <= -RM_W'(trig.sin_v);
                rm_r[5]  <= RM_W'(ONE_Q16);
                rm_r[8]  <= RM_W'(trig.sin_v);
                rm_r[10] <= RM_W'(trig.cos_v);
                state_r  <= S_MAC;
              end
              OP_ROT_Z: begin
                rm_r[0]  <= RM_W'(trig.cos_v);
                rm_r[1]  <= RM_W'(trig.sin_v);
                rm_r[4]  <= -RM_W'(trig.sin_v);
                rm_r[5]  <= RM_W'(trig.cos_v);
                rm_r[10] <= RM_W'(ONE_Q16);
                state_r  <= S_MAC;
              end
              default: begin
                state_r <= S_BUILD;
              end
            endcase
          end
        end

        // axis rotation matrix from products
        S_BUILD: begin
          step_r <= step_r + 1'b1;
          if (p_v_r) begin
            case (p_tag_r[3:0])
              4'd0:  t_r[0] <= q_b;
              4'd1:  t_r[1] <= q_b;
              4'd2:  t_r[2] <= q_b;
              4'd3:  t_r[3] <= q_b;
              4'd4:  t_r[4] <= q_b;
              4'd5:  t_r[5] <= q_b;
              4'd6:  t_r[6] <= q_b;
              4'd7:  t_r[7] <= q_b;
              4'd8:  t_r[8] <= q_b;
              4'd9:  rm_r[0]  <= q_b + RM_W'(trig.cos_v);
              4'd10: rm_r[5]  <= q_b + RM_W'(trig.cos_v);
              4'd11: rm_r[10] <= q_b + RM_W'(trig.cos_v);
              4'd12: begin
                rm_r[1] <= q_b + t_r[8];
                rm_r[4] <= q_b - t_r[8];
              end
              4'd13: begin
                rm_r[6] <= q_b + t_r[6];
                rm_r[9] <= q_b - t_r[6];
              end
              4'd14: begin
                rm_r[2] <= q_b - t_r[7];
                rm_r[8] <= q_b + t_r[7];
              end
              default: begin
                rm_r[15] <= RM_W'(ONE_Q16);
              end
            endcase
          end
          if (step_r == 7'd15) begin
            step_r  <= '0;
            state_r <= S_MAC;
          end
        end

        // matrix product into the spare bank
        S_MAC: begin
          step_r <= step_r + 1'b1;
          if (p_v_r) begin
            acc_r <= acc_sum;
          end
          if (step_r == 7'd66) begin
            bank_r  <= ~bank_r;
            vld_r   <= '1;
            step_r  <= '0;
            state_r <= S_STREAM;
          end
        end

        // read out through the output register
        S_STREAM: begin
          if (stream_issue) begin
            step_r <= step_r + 1'b1;
          end
          if (pend_r) begin
            out_valid_r <= 1'b1;
            out_index_r <= rd_idx_r;
            out_value_r <= rdata_eff;
            out_last_r  <= (rd_idx_r == IDX_W'(ELEMS - 1));
            out_err_r   <= err_r;
            if (rd_idx_r == IDX_W'(ELEMS - 1)) begin
              state_r <= S_IDLE;
            end
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {4'b0, out_value_r, out_index_r};
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_err_r;

endmodule

### bench/testbench.sv
module testbench;
  import mar_pkg::*;

  // operation codes the block must ignore
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
  localparam int ITERS = CORDIC_ITER_DEF;
  localparam longint unsigned UNIT_LSQ = 64'h1_0000_0000;

  typedef struct {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     err;
  } elem_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic [OP_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;
  logic [0:0] out_tuser;

  // predicted matrix and pending element results
  logic signed [DATA_W-1:0] pred_mat [ELEMS];
  elem_t pending_elems[$];
  longint arctan_q30 [32] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
    15, 7, 3, 1, 0, 0};

  int mismatches;
  int items_sent;
  int elems_seen;
  int axis_errors_seen;
  int hold_req;
  int hold_left;
  bit quiet;

  matrix_axis_angle_rotate_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // q16 fixed point helpers
  function automatic longint q16_mul(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic logic signed [DATA_W-1:0] round_clip(longint acc);
    longint v;
    v = (acc + 32768) >>> 16;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[DATA_W-1:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint unit_comp(longint v, longint unsigned len);
    longint unsigned mag;
    longint q;
    mag = (v < 0) ? -v : v;
    q = longint'((mag * 65536 + len / 2) / len);
    return (v < 0) ? -q : q;
  endfunction

  // cordic sine and cosine of a q10.6 degree angle
  task automatic trig_of(input logic signed [ANG_W-1:0] ang, output longint s,
                         output longint c);
    longint r, x, y, z, nx;
    bit neg_both, neg_cos;
    r = longint'(ang) % 23040;
    neg_both = 0;
    neg_cos = 0;
    if (r < 0) r += 23040;
    if (r >= 11520) begin
      r -= 11520;
      neg_both = 1;
    end
    if (r > 5760) begin
      r = 11520 - r;
      neg_cos = 1;
    end
    z = r * 292818;
    x = 652032874;
    y = 0;
    for (int i = 0; i < ITERS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan_q30[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan_q30[i];
      end
      x = nx;
    end
    x = (x + 8192) >>> 14;
    y = (y + 8192) >>> 14;
    if (neg_cos) x = -x;
    if (neg_both) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endtask

  // a' = a*c + b*s, b' = b*c - a*s over four rows
  task automatic turn_columns(input int ca, input int cb, input longint c, input longint s);
    longint va, vb;
    for (int r = 0; r < 4; r++) begin
      va = pred_mat[4*ca+r];
      vb = pred_mat[4*cb+r];
      pred_mat[4*ca+r] = round_clip(va * c + vb * s);
      pred_mat[4*cb+r] = round_clip(vb * c - va * s);
    end
  endtask

  // rodrigues rotation, returns 0 on a zero axis
  function automatic bit turn_about_axis(longint x, longint y, longint z, longint s,
                                         longint c);
    longint unsigned ax, ay, az, lsq, len;
    longint rm [16];
    longint acc, nc, xy, yz, zx;
    logic signed [DATA_W-1:0] res [16];
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    lsq = ax * ax + ay * ay + az * az;
    if (lsq == 0) return 0;
    if (lsq != UNIT_LSQ) begin
      len = int_sqrt(lsq);
      x = unit_comp(x, len);
      y = unit_comp(y, len);
      z = unit_comp(z, len);
    end
    nc = 65536 - c;
    xy = q16_mul(x, y);
    yz = q16_mul(y, z);
    zx = q16_mul(z, x);
    for (int k = 0; k < 16; k++) rm[k] = 0;
    rm[0] = q16_mul(q16_mul(x, x), nc) + c;
    rm[1] = q16_mul(xy, nc) + q16_mul(z, s);
    rm[2] = q16_mul(zx, nc) - q16_mul(y, s);
    rm[4] = q16_mul(xy, nc) - q16_mul(z, s);
    rm[5] = q16_mul(q16_mul(y, y), nc) + c;
    rm[6] = q16_mul(yz, nc) + q16_mul(x, s);
    rm[8] = q16_mul(zx, nc) + q16_mul(y, s);
    rm[9] = q16_mul(yz, nc) - q16_mul(x, s);
    rm[10] = q16_mul(q16_mul(z, z), nc) + c;
    rm[15] = 65536;
    for (int col = 0; col < 4; col++)
      for (int row = 0; row < 4; row++) begin
        acc = 0;
        for (int k = 0; k < 4; k++)
          acc += longint'(pred_mat[4*k+row]) * rm[4*col+k];
        res[4*col+row] = round_clip(acc);
      end
    for (int k = 0; k < 16; k++) pred_mat[k] = res[k];
    return 1;
  endfunction

  // apply one command to the predicted matrix and queue its elements
  task automatic predict_command(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                 input logic signed [DATA_W-1:0] val,
                                 input logic signed [ANG_W-1:0] ang,
                                 input logic signed [DATA_W-1:0] x,
                                 input logic signed [DATA_W-1:0] y,
                                 input logic signed [DATA_W-1:0] z);
    longint s, c;
    bit err;
    elem_t e;
    err = 0;
    s = 0;
    c = 0;
    if (op == OP_LOAD) begin
      pred_mat[idx] = val;
      return;
    end
    if (op > OP_READ) return;
    if (op != OP_READ) trig_of(ang, s, c);
    case (op)
      OP_AXIS:  err = !turn_about_axis(x, y, z, s, c);
      OP_ROT_X: turn_columns(1, 2, c, s);
      OP_ROT_Y: turn_columns(0, 2, c, -s);
      OP_ROT_Z: turn_columns(0, 1, c, s);
      default: ;
    endcase
    for (int k = 0; k < ELEMS; k++) begin
      e.idx = k;
      e.value = pred_mat[k];
      e.last = (k == ELEMS - 1);
      e.err = err;
      pending_elems.push_back(e);
    end
  endtask

  // send one item after the given gap, predict on acceptance
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic signed [DATA_W-1:0] val,
                           input logic signed [ANG_W-1:0] ang,
                           input logic signed [DATA_W-1:0] x,
                           input logic signed [DATA_W-1:0] y,
                           input logic signed [DATA_W-1:0] z, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {4'b0, z, y, x, ang, val, idx};
    do @(negedge clk); while (!in_tready);
    predict_command(op, idx, val, ang, x, y, z);
    if (op <= OP_READ) items_sent++;
    @(posedge clk);
  endtask

  function automatic int rand_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  task automatic rotate_item(input logic [OP_W-1:0] op, input logic signed [ANG_W-1:0] ang);
    send_item(op, '0, '0, ang, '0, '0, '0, rand_gap());
  endtask

  task automatic axis_item(input logic signed [ANG_W-1:0] ang,
                           input logic signed [DATA_W-1:0] x,
                           input logic signed [DATA_W-1:0] y,
                           input logic signed [DATA_W-1:0] z);
    send_item(OP_AXIS, '0, '0, ang, x, y, z, rand_gap());
  endtask

  task automatic load_item(input logic [IDX_W-1:0] idx, input logic signed [DATA_W-1:0] val);
    send_item(OP_LOAD, idx, val, '0, '0, '0, '0, rand_gap());
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
  endtask

  // extremes of element values and indexes, read out, ignored codes
  task automatic test_loads();
    send_item(OP_READ, '0, '0, '0, '0, '0, '0, 0);
    load_item(4'd0, 32'sh7fffffff);
    load_item(4'd15, 32'sh80000000);
    load_item(4'd5, -32'sd1);
    send_item(OP_SPARE_6, 4'd5, 32'sd7, '0, '0, '0, '0, 0);
    send_item(OP_SPARE_7, 4'd10, 32'sd9, '0, '0, '0, '0, 0);
    send_item(OP_READ, '0, '0, '0, '0, '0, '0, 0);
  endtask

  // column rotations, saturating products and angle quadrants
  task automatic test_column_turns();
    rotate_item(OP_ROT_X, 16'sd5760);
    rotate_item(OP_ROT_Y, 16'sd11520);
    rotate_item(OP_ROT_Z, 16'sd17280);
    rotate_item(OP_ROT_X, -16'sd23040);
    rotate_item(OP_ROT_Y, 16'sh7fff);
    rotate_item(OP_ROT_Z, 16'sh8000);
    rotate_item(OP_ROT_X, 16'sd0);
  endtask

  // axis rotate: exact unit axis, zero axis, extreme components
  task automatic test_axis_cases();
    load_item(4'd0, ONE_Q16);
    load_item(4'd15, ONE_Q16);
    load_item(4'd5, ONE_Q16);
    axis_item(16'sd2880, 32'sd65536, 32'sd0, 32'sd0);
    axis_item(16'sd1000, 32'sd0, 32'sd0, 32'sd0);
    axis_item(-16'sd3000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    axis_item(16'sd7000, 32'sh7fffffff, -32'sd5, 32'sd1);
    axis_item(16'sd123, 32'sd0, 32'sd0, -32'sd1);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_axis_comp(int kind);
    case (kind)
      0: return $urandom();
      1: return $signed($urandom_range(0, 262144)) - 32'sd131072;
      default: return $signed($urandom_range(0, 32)) - 32'sd16;
    endcase
  endfunction

  // mostly well formed command mix with random content
  task automatic test_random(input int count);
    int pick, kind;
    logic signed [DATA_W-1:0] val;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (n == count / 3) quiet = 1;
      if (n == count / 3 + 20) quiet = 0;
      if (pick < 25) begin
        val = ($urandom_range(0, 1) != 0) ? $urandom() :
              $signed($urandom_range(0, 524288)) - 32'sd262144;
        load_item($urandom_range(0, 15), val);
      end else if (pick < 32) begin
        send_item(OP_READ, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom(), rand_gap());
      end else if (pick < 35) begin
        send_item(($urandom_range(0, 1) != 0) ? OP_SPARE_6 : OP_SPARE_7, $urandom(),
                  $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), rand_gap());
        n--;
      end else if (pick < 65) begin
        kind = $urandom_range(0, 9);
        if (kind == 0)
          axis_item($urandom(), '0, '0, '0);
        else
          axis_item($urandom(), rand_axis_comp(kind % 3), rand_axis_comp(kind % 3),
                    rand_axis_comp((kind + 1) % 3));
      end else begin
        rotate_item(OP_ROT_X + $urandom_range(0, 2), $urandom());
      end
    end
  endtask

  // receiver holds off while commands pile up, then the sender waits for the drain
  task automatic test_backpressure();
    @(negedge clk);
    hold_req = 600;
    @(posedge clk);
    for (int n = 0; n < 6; n++)
      send_item(OP_ROT_X + (n % 3), $urandom(), '0, $urandom(), '0, '0, '0, 0);
    wait_drained();
    axis_item(16'sd640, 32'sd3, 32'sd4, 32'sd0);
  endtask

  // result checker
  always @(posedge clk) begin
    elem_t e;
    if (rst_n && out_tvalid && out_tready) begin
      elems_seen++;
      if (out_tuser[0]) axis_errors_seen++;
      if (pending_elems.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected element idx=%0d value=%0d", out_tdata[3:0], out_tdata[35:4]);
      end else begin
        e = pending_elems.pop_front();
        if (out_tdata[3:0] !== e.idx || out_tdata[35:4] !== e.value
            || out_tlast !== e.last || out_tuser[0] !== e.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp idx=%0d value=%0d last=%0b err=%0b, got %0d %0d %0b %0b",
                     e.idx, e.value, e.last, e.err, out_tdata[3:0],
                     $signed(out_tdata[35:4]), out_tlast, out_tuser[0]);
        end
      end
    end
  end

  // receiver stalls, mostly short, some long
  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != 0) begin
      hold_left <= hold_req - 1;
      hold_req = 0;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2) hold_left <= $urandom_range(15, 60);
      out_tready <= (r >= 25);
    end
  end

  // run limit
  initial begin
    #30000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    mismatches = 0;
    items_sent = 0;
    elems_seen = 0;
    axis_errors_seen = 0;
    hold_req = 0;
    quiet = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    for (int k = 0; k < ELEMS; k++) pred_mat[k] = (k % 5 == 0) ? ONE_Q16 : '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_loads();
    test_column_turns();
    test_axis_cases();
    test_backpressure();
    test_random(200);
    wait_drained();
    repeat (300) @(posedge clk);
    $display("covered %0d commands: loads, read out, X/Y/Z and axis turns, ignored codes",
             items_sent);
    $display("checked %0d elements, %0d flagged zero axis, %0d mismatches",
             elems_seen, axis_errors_seen, mismatches);
    if (mismatches == 0 && pending_elems.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

### filelist.f
hdl/mar_pkg.sv
hdl/mar_cordic.sv
hdl/mar_norm.sv
hdl/matrix_axis_angle_rotate_core.sv
bench/testbench.sv
